/* rtl/core/spg_pkg.sv */
package spg_pkg;

    localparam int LANES_MAX = 4;
    localparam int POS_W     = 32;
    localparam int STEPS_W   = 32;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Input tdata: axis, move_dir, step_count, endstops (39 bits -> 40)
    localparam int S_TDATA_W = 40;
    // Output tdata: step_pulses, dir_levels, done_mask, pos_axis0..3 (140 -> 144)
    localparam int M_TDATA_W = 144;

    // Request kinds carried in tuser
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_MOVE = 2'd1;
    localparam logic [1:0] REQ_HOME = 2'd2;
    localparam logic [1:0] REQ_HALT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_DIR = 3'd4;

    localparam logic [TICK_W-1:0] PERIOD_RESET [LANES_MAX] =
        '{16'd6, 16'd15, 16'd10, 16'd4};

    typedef struct packed {
        logic [1:0]         req_type;
        logic [1:0]         axis;
        logic               move_dir;
        logic [STEPS_W-1:0] step_count;
    } lane_cmd_t;

    typedef struct packed {
        logic                    pulse;
        logic                    dir;
        logic                    done;
        logic signed [POS_W-1:0] pos;
    } lane_status_t;

endpackage

/* rtl/core/spg_lane.sv */
module spg_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  spg_pkg::lane_cmd_t          cmd,
    input  logic                        endstop,
    input  logic                        home_dir,
    input  logic                        period_we,
    input  logic [spg_pkg::TICK_W-1:0]  period_data,
    output spg_pkg::lane_status_t       status
);
    import spg_pkg::*;

    localparam logic [1:0] LANE_SEL = LANE_IDX[1:0];

    logic [TICK_W-1:0]       period_reg;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic                    dir_reg, dir_next;
    logic                    homing_reg, homing_next;
    logic [STEPS_W-1:0]      steps_reg, steps_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic                    pulse;

    logic [TICK_W-1:0] per_eff;
    logic [TICK_W:0]   tick_inc;
    logic              hit;
    logic              clr;
    logic              sel;

    assign per_eff  = (period_reg == '0) ? TICK_W'(1) : period_reg;
    assign tick_inc = {1'b0, tick_reg} + (TICK_W+1)'(1);
    assign hit      = tick_inc >= {1'b0, per_eff};
    assign clr      = endstop && (dir_reg == home_dir);
    assign sel      = (cmd.axis == LANE_SEL);

    always_comb
    begin
        tick_next   = tick_reg;
        dir_next    = dir_reg;
        homing_next = homing_reg;
        steps_next  = steps_reg;
        pos_next    = pos_reg;
        pulse       = 1'b0;
        unique case (cmd.req_type)
            REQ_TICK:
            begin
                if (hit)
                begin
                    tick_next = '0;
                    if (clr)
                    begin
                        homing_next = 1'b0;
                        steps_next  = '0;
                        pos_next    = '0;
                    end
                    if (steps_next != '0)
                    begin
                        pulse      = 1'b1;
                        steps_next = steps_next - STEPS_W'(1);
                        pos_next   = dir_reg ? pos_next + POS_W'(1) : pos_next - POS_W'(1);
                    end
                    if (homing_next)
                        pulse = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc[TICK_W-1:0];
                end
            end
            REQ_MOVE:
            begin
                if (sel)
                begin
                    dir_next    = cmd.move_dir;
                    steps_next  = cmd.step_count;
                    homing_next = 1'b0;
                end
            end
            REQ_HOME:
            begin
                if (sel)
                begin
                    homing_next = 1'b1;
                    steps_next  = '0;
                    dir_next    = home_dir;
                end
            end
            REQ_HALT:
            begin
                if (sel)
                begin
                    steps_next  = '0;
                    homing_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET[LANE_IDX];
            tick_reg   <= '0;
            dir_reg    <= 1'b0;
            homing_reg <= 1'b0;
            steps_reg  <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            if (period_we)
                period_reg <= period_data;
            if (accept)
            begin
                tick_reg   <= tick_next;
                dir_reg    <= dir_next;
                homing_reg <= homing_next;
                steps_reg  <= steps_next;
                pos_reg    <= pos_next;
            end
        end
    end

    // State after this transaction, registered downstream
    assign status.pulse = pulse;
    assign status.dir   = dir_next;
    assign status.done  = (steps_next == '0) && !homing_next;
    assign status.pos   = pos_next;

endmodule

/* rtl/core/spg_merge.sv */
module spg_merge (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  spg_pkg::lane_status_t           lanes [spg_pkg::LANES_MAX],
    input  logic                            out_take,
    output logic                            out_valid,
    output logic [spg_pkg::M_TDATA_W-1:0]   out_data
);
    import spg_pkg::*;

    logic                 valid_reg, valid_next;
    logic [M_TDATA_W-1:0] data_reg;
    logic [M_TDATA_W-1:0] packed_word;
    logic [LANES_MAX-1:0] pulses, dirs, dones;

    always_comb
    begin
        packed_word = '0;
        for (int a = 0; a < LANES_MAX; a++)
        begin
            pulses[a] = lanes[a].pulse;
            dirs[a]   = lanes[a].dir;
            dones[a]  = lanes[a].done;
            packed_word[3*LANES_MAX + a*POS_W +: POS_W] = lanes[a].pos;
        end
        packed_word[0 +: LANES_MAX]           = pulses;
        packed_word[LANES_MAX +: LANES_MAX]   = dirs;
        packed_word[2*LANES_MAX +: LANES_MAX] = dones;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (out_take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= packed_word;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/multi_axis_stepper_pulse_generator.sv */
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: req_type; tdata: axis, move_dir,
//                                               step_count, endstops
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: step_pulses, dir_levels, done_mask,
//                                               pos_axis0..3
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// One transaction per cycle while s_axis_tready is high. Every lane computes its next
// state in the same cycle the request is taken; the result is registered in the output register.
// s_axis_tready drops only while a result sits unclaimed and m_axis_tready is low.
// Reset loads the period defaults and clears all lane state; no clearing pass.
// cfg_ready is always high.
module multi_axis_stepper_pulse_generator #(
    parameter int NUM_AXES = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] axis, [2] move_dir, [34:3] step_count, [38:35] endstops, [39] zero
    input  logic [spg_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                        s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] step_pulses, [7:4] dir_levels, [11:8] done_mask,
    // [43:12] pos_axis0, [75:44] pos_axis1, [107:76] pos_axis2,
    // [139:108] pos_axis3, [143:140] zero
    output logic [spg_pkg::M_TDATA_W-1:0]     m_axis_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spg_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import spg_pkg::*;

    // Lanes past the fourth have no registers or fields
    localparam int LANES = (NUM_AXES < LANES_MAX) ? NUM_AXES : LANES_MAX;

    logic                 accept;
    logic                 cfg_we;
    lane_cmd_t            cmd;
    logic [LANES_MAX-1:0] endstops;
    logic [LANES_MAX-1:0] home_dir_reg;
    lane_status_t         lane_st [LANES_MAX];

    assign cfg_ready     = 1'b1;
    assign cfg_we        = cfg_valid && cfg_ready;
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cmd.req_type   = s_axis_tuser;
    assign cmd.axis       = s_axis_tdata[1:0];
    assign cmd.move_dir   = s_axis_tdata[2];
    assign cmd.step_count = s_axis_tdata[34:3];
    assign endstops       = s_axis_tdata[38:35];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            home_dir_reg <= '0;
        else if (cfg_we && cfg_index == CFG_HOME_DIR)
            home_dir_reg <= cfg_data[LANES_MAX-1:0];
    end

    // One lane per axis; absent lanes report zeros
    for (genvar a = 0; a < LANES_MAX; a++)
    begin : g_lane
        if (a < LANES)
        begin : g_on
            spg_lane #(
                .LANE_IDX (a)
            ) u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .accept      (accept),
                .cmd         (cmd),
                .endstop     (endstops[a]),
                .home_dir    (home_dir_reg[a]),
                .period_we   (cfg_we && cfg_index == CFG_PERIOD0 + CFG_IDX_W'(a)),
                .period_data (cfg_data),
                .status      (lane_st[a])
            );
        end
        else
        begin : g_off
            assign lane_st[a] = '0;
        end
    end

    spg_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .lanes     (lane_st),
        .out_take  (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

/* tb/sv/stepper_lane_checker.sv */
module stepper_lane_checker #(
    parameter int NUM_AXES = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [spg_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]                    s_axis_tuser,

    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [spg_pkg::M_TDATA_W-1:0] m_axis_tdata,

    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spg_pkg::CFG_DAT_W-1:0] cfg_data,

    output int unsigned                   fail_count,
    output int unsigned                   pending
);
    import spg_pkg::*;

    localparam int LANES = (NUM_AXES < LANES_MAX) ? NUM_AXES : LANES_MAX;
    localparam int PRINT_MAX = 40;

    typedef struct packed {
        logic [3:0]                      pulses;
        logic [3:0]                      dirs;
        logic [3:0]                      done;
        logic [LANES_MAX-1:0][POS_W-1:0] pos;
    } lane_report_t;

    // shadow copy of the lane state and the register file
    logic [TICK_W-1:0]  period_q [LANES_MAX];
    logic [3:0]         home_mask;
    logic               dir_q    [LANES_MAX];
    logic [STEPS_W-1:0] left_q   [LANES_MAX];
    logic [POS_W-1:0]   pos_q    [LANES_MAX];
    logic               homing_q [LANES_MAX];
    logic [TICK_W-1:0]  ticks_q  [LANES_MAX];

    lane_report_t status_expected [$];
    int unsigned  errs;
    int unsigned  seen;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errs++;
        if (errs <= PRINT_MAX)
            $display("%0t checker: %s got 0x%08h want 0x%08h (result %0d)",
                     $time, what, got, want, seen);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // endstop check first, then a pending step, then the homing pulse
    function automatic logic service_lane(input int a, input logic [3:0] stops);
        logic pulse;
        pulse = 1'b0;
        if (stops[a] && dir_q[a] == home_mask[a]) begin
            homing_q[a] = 1'b0;
            pos_q[a]    = '0;
            left_q[a]   = '0;
        end
        if (left_q[a] != '0) begin
            pulse     = 1'b1;
            left_q[a] = left_q[a] - 1'b1;
            pos_q[a]  = dir_q[a] ? pos_q[a] + 1'b1 : pos_q[a] - 1'b1;
        end
        if (homing_q[a])
            pulse = 1'b1;
        return pulse;
    endfunction

    task automatic advance_lanes(input logic [1:0] kind, input logic [S_TDATA_W-1:0] data,
                                 output lane_report_t want);
        logic [1:0]         ax;
        logic               mdir;
        logic [STEPS_W-1:0] cnt;
        logic [3:0]         stops;
        int unsigned        per;
        int unsigned        nxt;
        ax    = data[1:0];
        mdir  = data[2];
        cnt   = data[34:3];
        stops = data[38:35];
        want  = '0;
        if (kind == REQ_TICK) begin
            for (int a = 0; a < LANES; a++) begin
                per = (period_q[a] == '0) ? 1 : period_q[a];
                nxt = ticks_q[a] + 1;
                if (nxt >= per) begin
                    ticks_q[a]     = '0;
                    want.pulses[a] = service_lane(a, stops);
                end else begin
                    ticks_q[a] = nxt[TICK_W-1:0];
                end
            end
        end else if (int'(ax) < LANES) begin
            case (kind)
                REQ_MOVE: begin
                    dir_q[ax]    = mdir;
                    left_q[ax]   = cnt;
                    homing_q[ax] = 1'b0;
                end
                REQ_HOME: begin
                    homing_q[ax] = 1'b1;
                    left_q[ax]   = '0;
                    dir_q[ax]    = home_mask[ax];
                end
                default: begin
                    left_q[ax]   = '0;
                    homing_q[ax] = 1'b0;
                end
            endcase
        end
        for (int a = 0; a < LANES; a++) begin
            want.dirs[a] = dir_q[a];
            want.done[a] = (left_q[a] == '0) && !homing_q[a];
            want.pos[a]  = pos_q[a];
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        lane_report_t want;
        lane_report_t got;
        if (!rst_n) begin
            period_q[0] = 16'd6;
            period_q[1] = 16'd15;
            period_q[2] = 16'd10;
            period_q[3] = 16'd4;
            home_mask   = '0;
            for (int a = 0; a < LANES_MAX; a++) begin
                dir_q[a]    = 1'b0;
                left_q[a]   = '0;
                pos_q[a]    = '0;
                homing_q[a] = 1'b0;
                ticks_q[a]  = '0;
            end
            status_expected.delete();
            errs = 0;
            seen = 0;
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index < CFG_HOME_DIR)
                    period_q[2'(cfg_index - CFG_PERIOD0)] = cfg_data[TICK_W-1:0];
                else if (cfg_index == CFG_HOME_DIR)
                    home_mask = cfg_data[3:0];
            end
            // retire before predicting: a result never belongs to the
            // transaction taken at the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.pulses = m_axis_tdata[3:0];
                got.dirs   = m_axis_tdata[7:4];
                got.done   = m_axis_tdata[11:8];
                for (int a = 0; a < LANES_MAX; a++)
                    got.pos[a] = m_axis_tdata[12 + POS_W*a +: POS_W];
                if (status_expected.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(got.done), 32'h0);
                end else begin
                    want = status_expected.pop_front();
                    check_field("step_pulses", 32'(got.pulses), 32'(want.pulses));
                    check_field("dir_levels", 32'(got.dirs), 32'(want.dirs));
                    check_field("done_mask", 32'(got.done), 32'(want.done));
                    for (int a = 0; a < LANES_MAX; a++)
                        check_field($sformatf("pos_axis%0d", a), got.pos[a], want.pos[a]);
                end
                check_field("tdata pad", 32'(m_axis_tdata[143:140]), 32'h0);
                seen++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_lanes(s_axis_tuser, s_axis_tdata, want);
                status_expected.push_back(want);
            end
            fail_count <= errs;
            pending    <= status_expected.size();
        end
    end

endmodule

/* tb/sv/multi_axis_stepper_pulse_generator_tb.sv */
// Top of the stepper step/dir testbench: clock, reset, stimulus and verdict.
// Prediction and compare live in stepper_lane_checker.
module multi_axis_stepper_pulse_generator_tb;
    import spg_pkg::*;

    localparam int NUM_AXES    = 4;
    // Cycles with no transaction on any channel before we give up. Worst honest
    // case is a long source gap or a long sink stall.
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 225;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = REQ_TICK;

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_PERIOD0;
    logic [CFG_DAT_W-1:0] cfg_data      = '0;

    int unsigned          fail_count;
    int unsigned          pending;
    int unsigned          quiet_cycles  = 0;
    int unsigned          items_sent    = 0;

    // Gap modes flip now and then so both long busy stretches and choppy
    // stretches show up on each side.
    bit                   src_gaps      = 1'b1;
    bit                   sink_gaps     = 1'b1;

    always #5 clk = ~clk;

    multi_axis_stepper_pulse_generator #(
        .NUM_AXES (NUM_AXES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    stepper_lane_checker #(
        .NUM_AXES (NUM_AXES)
    ) lane_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Watchdog: any accepted transaction on any channel resets the count.
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("multi_axis_stepper_pulse_generator_tb: errors");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result sink: bursts of ready broken by random stalls.
    initial begin : sink
        int unsigned run_len;
        int unsigned stall_len;
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                sink_gaps = !sink_gaps;
            run_len   = $urandom_range(1, 16);
            stall_len = pick_gap(sink_gaps);
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (stall_len != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // One request transaction. tvalid stays high into the next call when no
    // gap follows, so it is never dropped and raised in the same step.
    task automatic send_item(input logic [1:0] kind, input logic [1:0] ax,
                             input logic mdir, input logic [31:0] cnt,
                             input logic [3:0] stops);
        int unsigned gap;
        if ($urandom_range(0, 63) == 0)
            src_gaps = !src_gaps;
        gap = pick_gap(src_gaps);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, stops, cnt, mdir, ax};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // Tick with random filler in the fields a tick ignores.
    task automatic tick(input logic [3:0] stops);
        send_item(REQ_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  $urandom, stops);
    endtask

    function automatic logic [3:0] pick_stops();
        return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'h0;
    endfunction

    // Small counts let moves finish; the rest exercise the full field.
    function automatic logic [31:0] pick_steps();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return $urandom_range(0, 12);
            7:                   return $urandom;
            8:                   return 32'hFFFF_FFFF;
            default:             return 32'h1 << $urandom_range(0, 31);
        endcase
    endfunction

    // Drain: let the last transaction land in the checker, wait for all
    // results, then let the output register settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Rewrite every register; optionally poke an index with no register behind it.
    task automatic load_settings(input logic [15:0] p0, input logic [15:0] p1,
                                 input logic [15:0] p2, input logic [15:0] p3,
                                 input logic [3:0] mask, input bit poke_unused);
        cfg_write(CFG_PERIOD0,        p0);
        cfg_write(CFG_PERIOD0 + 3'd1, p1);
        cfg_write(CFG_PERIOD0 + 3'd2, p2);
        cfg_write(CFG_PERIOD0 + 3'd3, p3);
        // upper data bits are don't-care for the mask; keep them noisy
        cfg_write(CFG_HOME_DIR, {12'($urandom_range(0, 4095)), mask});
        if (poke_unused)
            cfg_write(CFG_HOME_DIR + 3'd1, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Random traffic built mostly from plausible sequences: a move followed by
    // ticks, a home followed by ticks until the endstop trips, a halt. The
    // remainder is raw noise on every field.
    task automatic run_random(input int unsigned n);
        int unsigned start;
        logic [1:0]  ax;
        start = items_sent;
        while (items_sent - start < n) begin
            ax = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    send_item(REQ_MOVE, ax, 1'($urandom_range(0, 1)), pick_steps(),
                              4'($urandom_range(0, 15)));
                    repeat ($urandom_range(1, 24)) tick(pick_stops());
                end
                4, 5: begin
                    send_item(REQ_HOME, ax, 1'($urandom_range(0, 1)), $urandom,
                              4'($urandom_range(0, 15)));
                    repeat ($urandom_range(0, 12)) tick(pick_stops() & ~(4'b1 << ax));
                    tick(pick_stops() | (4'b1 << ax));
                    repeat ($urandom_range(0, 3)) tick(pick_stops());
                end
                6: begin
                    send_item(REQ_HALT, ax, 1'($urandom_range(0, 1)), $urandom,
                              4'($urandom_range(0, 15)));
                    repeat ($urandom_range(0, 4)) tick(pick_stops());
                end
                default: begin
                    send_item(2'($urandom_range(0, 3)), ax, 1'($urandom_range(0, 1)),
                              $urandom, 4'($urandom_range(0, 15)));
                end
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass on the reset settings (periods 6/15/10/4, home dir 0).
        send_item(REQ_MOVE, 2'd0, 1'b1, 32'd3, 4'h0);
        send_item(REQ_MOVE, 2'd1, 1'b0, 32'hFFFF_FFFF, 4'h0);
        send_item(REQ_MOVE, 2'd2, 1'b1, 32'd0, 4'h0);
        send_item(REQ_HOME, 2'd3, 1'b1, 32'd7, 4'h0);
        // lane 3 gets homing pulses, lane 0 its first step
        repeat (6) tick(4'h0);
        // endstops high on a tick where no lane is due for service: nothing clears yet
        tick(4'hF);
        send_item(REQ_HALT, 2'd1, 1'b0, 32'd0, 4'h0);
        // home issued with the endstop already high: ends at next service, no pulse
        send_item(REQ_HOME, 2'd0, 1'b0, 32'd0, 4'hF);
        repeat (6) tick(4'hF);
        send_item(REQ_MOVE, 2'd3, 1'b1, 32'h8000_0000, 4'h0);
        tick(4'hA);
        // every tdata bit but the top pad bit high, then a tick carrying high filler bits
        send_item(REQ_HALT, 2'd3, 1'b1, 32'hFFFF_FFFF, 4'hF);
        send_item(REQ_TICK, 2'd3, 1'b1, 32'hFFFF_FFFF, 4'h0);
        drain();

        // Fastest service on every lane, all lanes home upward.
        load_settings(16'd1, 16'd1, 16'd1, 16'd1, 4'hF, 1'b0);
        run_random(PHASE_ITEMS);
        drain();

        // Period zero on lane 0, slowest possible on lane 3.
        load_settings(16'd0, 16'd2, 16'd3, 16'd65535, 4'h0, 1'b1);
        run_random(PHASE_ITEMS);
        drain();

        // Lane 3 drops from the max to 5 with its count well past 5.
        load_settings(16'd65535, 16'd1, 16'd0, 16'd5, 4'h5, 1'b0);
        run_random(PHASE_ITEMS);
        drain();

        // Lane 0 drops from the max to 2; lane 1 goes to the max.
        load_settings(16'd2, 16'd65535, 16'd1, 16'd1, 4'hA, 1'b0);
        run_random(PHASE_ITEMS);
        drain();

        repeat (2) begin
            load_settings(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                          16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                          4'($urandom_range(0, 15)), 1'b0);
            run_random(PHASE_ITEMS);
            drain();
        end

        if (fail_count == 0)
            $display("multi_axis_stepper_pulse_generator_tb: clean");
        else
            $display("multi_axis_stepper_pulse_generator_tb: errors");
        $finish;
    end

endmodule
